[hw/rtl/fbm_pkg.sv]
// shared types, constants and helper functions for the fbm perlin noise block
// used by fbm_cfg, fbm_octave and fbm_perlin_noise_2d; depends on nothing
package fbm_pkg;

  localparam int unsigned MAX_OCTAVES_DEF     = 8;
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LACUN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 3'd4;

  localparam logic [31:0] RST_SEED    = 32'd0;
  localparam logic [3:0]  RST_OCTAVES = 4'd4;
  localparam logic [23:0] RST_BASE_FQ = 24'd65536;
  localparam logic [15:0] RST_LACUN   = 16'd8192;
  localparam logic [15:0] RST_PERSIST = 16'd16384;

  localparam logic [15:0] AMP_ONE  = 16'd32768;
  localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;

  localparam logic [31:0] HASH_MUL_A = 32'h045d9f3b;
  localparam logic [31:0] HASH_MUL_B = 32'h1b873593;

  localparam logic signed [21:0] FADE_15 = 22'sd983040;
  localparam logic signed [23:0] FADE_10 = 24'sd655360;
  localparam logic signed [18:0] ONE_Q16 = 19'sd65536;

  // width of one weighted octave term
  localparam int unsigned TERM_W = 44;

  typedef enum logic [1:0] {
    CFG_ST_START,
    CFG_ST_TABLE,
    CFG_ST_DIVIDE,
    CFG_ST_IDLE
  } cfg_state_e;

  typedef struct packed {
    logic        busy;
    logic [15:0] recip;
  } cfg_status_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] fold(input logic [31:0] h);
    return (h >> 16) ^ h;
  endfunction

  // gradient dot product, one of eight directions
  function automatic logic signed [18:0] grad_dot(input logic [2:0] code,
                                                 input logic signed [17:0] dx,
                                                 input logic signed [17:0] dy);
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] r;
    x = 19'(dx);
    y = 19'(dy);
    unique case (code)
      3'd0:    r = x + y;
      3'd1:    r = y - x;
      3'd2:    r = x - y;
      3'd3:    r = -x - y;
      3'd4:    r = x;
      3'd5:    r = -x;
      3'd6:    r = y;
      default: r = -y;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/fbm_perlin_noise_2d.sv]
// one item per cycle throughput while the output is not stalled and no rebuild is
// running, set by the fully pipelined octave units (one unit per octave)
// after reset and after each register write the block rebuilds its octave tables
// and the amplitude-sum reciprocal, holding in_ready_o low while it does so
// reset is asynchronous active low; registers take their documented reset values
module fbm_perlin_noise_2d #(
  parameter int unsigned MAX_OCTAVES     = fbm_pkg::MAX_OCTAVES_DEF,
  parameter int unsigned COORD_FRAC_BITS = fbm_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [31:0]              coord_x_i,
  input  logic signed [31:0]              coord_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [15:0]              noise_value_o
);

  localparam int unsigned OW     = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned IW     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int unsigned SUM_W  = fbm_pkg::TERM_W + IW;
  localparam int unsigned PROD_W = SUM_W + 17;
  // eight octave stages, then sum, scale and output
  localparam int unsigned NSTAGE = 11;

  fbm_pkg::cfg_status_t status;
  logic [31:0]   seed;
  logic [OW-1:0] used;
  logic [23:0]   freq_tab [MAX_OCTAVES];
  logic [15:0]   amp_tab  [MAX_OCTAVES];

  fbm_cfg #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .seed_o     (seed),
    .used_o     (used),
    .freq_tab_o (freq_tab),
    .amp_tab_o  (amp_tab)
  );

  // whole pipeline moves together unless the output item is stalled
  logic adv;
  logic [NSTAGE-1:0] vld_q;

  assign adv        = !vld_q[NSTAGE-1] || out_ready_i;
  assign in_ready_o = adv && !status.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTAGE-2:0], in_valid_i && in_ready_o};
    end
  end

  // one octave unit per octave, each with its own seed, scale and weight
  logic signed [fbm_pkg::TERM_W-1:0] term [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fbm_octave #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_octave (
      .clk_i    (clk_i),
      .en_i     (adv),
      .coord_x_i(coord_x_i),
      .coord_y_i(coord_y_i),
      .seed_i   (seed + 32'(i)),
      .freq_i   (freq_tab[i]),
      .amp_i    (amp_tab[i]),
      .active_i (OW'(i) < used),
      .term_o   (term[i])
    );
  end

  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-32:0] res;
  logic signed [15:0]       noise_d, noise_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      sum_d = sum_d + SUM_W'(term[i]);
    end
  end

  // floor scaling by the reciprocal, then saturation to the output range
  always_comb begin
    res = (PROD_W - 31)'(prod_q >>> 31);
    if (res > (PROD_W - 31)'(32767)) begin
      noise_d = 16'sh7fff;
    end else if (res < -(PROD_W - 31)'(32768)) begin
      noise_d = -16'sh8000;
    end else begin
      noise_d = res[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q   <= sum_d;
      prod_q  <= PROD_W'(sum_q) * PROD_W'($signed({1'b0, status.recip}));
      noise_q <= noise_d;
    end
  end

  assign out_valid_o   = vld_q[NSTAGE-1];
  assign noise_value_o = noise_q;

  // no item is taken while the tables are rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !in_ready_o)
    else $error("item accepted while configuration busy");

  // any register write starts a rebuild
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_index_i <= fbm_pkg::CFG_PERSIST) |=> status.busy)
    else $error("register write did not start a rebuild");

  // a stalled output freezes the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("pipeline advanced under output stall");

  // zero octaves give a zero reciprocal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!status.busy && used == '0) |-> status.recip == 16'd0)
    else $error("nonzero reciprocal with zero octaves");

endmodule

[hw/rtl/fbm_cfg.sv]
// configuration registers plus octave frequency/amplitude tables and the
// normalizing reciprocal, rebuilt after reset and after every write to one of the five registers; uses fbm_pkg
module fbm_cfg #(
  parameter int unsigned MAX_OCTAVES = fbm_pkg::MAX_OCTAVES_DEF,
  localparam int unsigned OW = $clog2(MAX_OCTAVES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output fbm_pkg::cfg_status_t            status_o,
  output logic [31:0]                     seed_o,
  output logic [OW-1:0]                   used_o,
  output logic [23:0]                     freq_tab_o [MAX_OCTAVES],
  output logic [15:0]                     amp_tab_o  [MAX_OCTAVES]
);

  localparam int unsigned IW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int unsigned CW = (OW > 4) ? OW : 4;
  localparam int unsigned TW = 17 + IW;

  fbm_pkg::cfg_state_e state_q, state_d;

  logic [31:0] seed_q;
  logic [3:0]  oct_q;
  logic [23:0] base_q;
  logic [15:0] lac_q;
  logic [15:0] pers_q;

  logic [OW-1:0] cnt_q;
  logic [23:0]   f_run_q;
  logic [15:0]   a_run_q;
  logic [TW-1:0] total_q;
  logic [TW-1:0] rem_q;
  logic [30:0]   quo_q;
  logic [4:0]    dcnt_q;
  logic [15:0]   recip_q;
  logic [23:0]   freq_q [MAX_OCTAVES];
  logic [15:0]   amp_q  [MAX_OCTAVES];

  logic [OW-1:0] used;
  logic [15:0]   pers_used;
  logic [39:0]   f_prod;
  logic [31:0]   a_prod;
  logic [23:0]   f_next;
  logic [15:0]   a_next;
  logic [TW:0]   rem_sh;
  logic          q_bit;
  logic [TW-1:0] rem_next;
  logic [30:0]   quo_next;

  always_comb begin
    used = (CW'(oct_q) > CW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES) : OW'(oct_q);
    pers_used = (pers_q > fbm_pkg::AMP_ONE) ? fbm_pkg::AMP_ONE : pers_q;
    f_prod = 40'(f_run_q) * 40'(lac_q);
    f_next = (f_prod[39:12] > 28'(fbm_pkg::FREQ_MAX)) ? fbm_pkg::FREQ_MAX : f_prod[35:12];
    a_prod = 32'(a_run_q) * 32'(pers_used);
    a_next = a_prod[30:15];
    // restoring division of 2^30 by the amplitude sum, one bit a cycle
    rem_sh   = {rem_q, (dcnt_q == 5'd30)};
    q_bit    = (rem_sh >= (TW + 1)'(total_q));
    rem_next = q_bit ? TW'(rem_sh - (TW + 1)'(total_q)) : rem_sh[TW-1:0];
    quo_next = {quo_q[29:0], q_bit};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbm_pkg::CFG_ST_START:  state_d = fbm_pkg::CFG_ST_TABLE;
      fbm_pkg::CFG_ST_TABLE: begin
        if (cnt_q == OW'(MAX_OCTAVES - 1)) state_d = fbm_pkg::CFG_ST_DIVIDE;
      end
      fbm_pkg::CFG_ST_DIVIDE: begin
        if (dcnt_q == 5'd0) state_d = fbm_pkg::CFG_ST_IDLE;
      end
      default: ;
    endcase
    if (cfg_we_i && (cfg_index_i <= fbm_pkg::CFG_PERSIST)) state_d = fbm_pkg::CFG_ST_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbm_pkg::CFG_ST_START;
      seed_q  <= fbm_pkg::RST_SEED;
      oct_q   <= fbm_pkg::RST_OCTAVES;
      base_q  <= fbm_pkg::RST_BASE_FQ;
      lac_q   <= fbm_pkg::RST_LACUN;
      pers_q  <= fbm_pkg::RST_PERSIST;
      cnt_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fbm_pkg::CFG_SEED:    seed_q <= cfg_data_i;
          fbm_pkg::CFG_OCTAVES: oct_q  <= cfg_data_i[3:0];
          fbm_pkg::CFG_BASE_FQ: base_q <= cfg_data_i[23:0];
          fbm_pkg::CFG_LACUN:   lac_q  <= cfg_data_i[15:0];
          fbm_pkg::CFG_PERSIST: pers_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == fbm_pkg::CFG_ST_START) cnt_q <= '0;
      else if (state_q == fbm_pkg::CFG_ST_TABLE) cnt_q <= cnt_q + OW'(1);
      if (state_q == fbm_pkg::CFG_ST_TABLE) dcnt_q <= 5'd30;
      else if (state_q == fbm_pkg::CFG_ST_DIVIDE) dcnt_q <= dcnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fbm_pkg::CFG_ST_START: begin
        f_run_q <= base_q;
        a_run_q <= fbm_pkg::AMP_ONE;
        total_q <= '0;
      end
      fbm_pkg::CFG_ST_TABLE: begin
        freq_q[cnt_q[IW-1:0]] <= f_run_q;
        amp_q[cnt_q[IW-1:0]]  <= a_run_q;
        if (cnt_q < used) total_q <= total_q + TW'(a_run_q);
        f_run_q <= f_next;
        a_run_q <= a_next;
        rem_q   <= '0;
        quo_q   <= '0;
      end
      fbm_pkg::CFG_ST_DIVIDE: begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        if (dcnt_q == 5'd0) recip_q <= (total_q == '0) ? 16'd0 : quo_next[15:0];
      end
      default: ;
    endcase
  end

  assign status_o.busy  = (state_q != fbm_pkg::CFG_ST_IDLE);
  assign status_o.recip = recip_q;
  assign seed_o         = seed_q;
  assign used_o         = used;
  assign freq_tab_o     = freq_q;
  assign amp_tab_o      = amp_q;

endmodule

[hw/rtl/fbm_octave.sv]
// one noise octave: eight register stages from coordinate to weighted term
// uses fbm_pkg for hash constants and the gradient function
module fbm_octave #(
  parameter int unsigned COORD_FRAC_BITS = fbm_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [31:0]                coord_x_i,
  input  logic signed [31:0]                coord_y_i,
  input  logic [31:0]                       seed_i,
  input  logic [23:0]                       freq_i,
  input  logic [15:0]                       amp_i,
  input  logic                              active_i,
  output logic signed [fbm_pkg::TERM_W-1:0] term_o
);

  localparam int unsigned PW = 16 + COORD_FRAC_BITS + 32;

  // stage a: coordinate times frequency
  logic signed [56:0] px_q, py_q;
  // stage 1
  logic [31:0] mx0_q, mx1_q, my0_q, my1_q;
  logic [15:0] tx1_q, ty1_q, t2x1_q, t2y1_q;
  logic signed [39:0] tax1_q, tay1_q;
  // stage 2
  logic [31:0] g0_q, g1_q, my0_2q, my1_2q;
  logic [15:0] tx2_q, ty2_q, t3x2_q, t3y2_q;
  logic signed [23:0] bx2_q, by2_q;
  // stage 3
  logic [2:0] c00_q, c10_q, c01_q, c11_q;
  logic [15:0] tx3_q, ty3_q;
  logic signed [17:0] u3_q, v3_q;
  // stage 4
  logic signed [18:0] n00_q, n10_q, n01_q, n11_q;
  logic signed [17:0] u4_q, v4_q;
  // stage 5
  logic signed [21:0] nx0_q, nx1_q;
  logic signed [17:0] v5_q;
  // stage 6
  logic signed [25:0] n6_q;
  // stage 7
  logic signed [fbm_pkg::TERM_W-1:0] term_q;

  logic signed [PW-1:0] pxe, pye;
  logic [31:0] ix, iy;
  logic [15:0] tx, ty;
  logic signed [17:0] tsx, tsy;
  logic signed [21:0] ax, ay;

  assign pxe = PW'(px_q);
  assign pye = PW'(py_q);
  assign ix  = pxe[16+COORD_FRAC_BITS+31:16+COORD_FRAC_BITS];
  assign iy  = pye[16+COORD_FRAC_BITS+31:16+COORD_FRAC_BITS];

  // fraction brought to sixteen bits
  if (COORD_FRAC_BITS >= 16) begin : g_frac_down
    assign tx = pxe[16+COORD_FRAC_BITS-1:COORD_FRAC_BITS];
    assign ty = pye[16+COORD_FRAC_BITS-1:COORD_FRAC_BITS];
  end else begin : g_frac_up
    assign tx = {pxe[16+COORD_FRAC_BITS-1:16], (16 - COORD_FRAC_BITS)'(0)};
    assign ty = {pye[16+COORD_FRAC_BITS-1:16], (16 - COORD_FRAC_BITS)'(0)};
  end

  assign tsx = $signed({2'b00, tx});
  assign tsy = $signed({2'b00, ty});
  assign ax  = 22'(tsx) * 22'sd6 - fbm_pkg::FADE_15;
  assign ay  = 22'(tsy) * 22'sd6 - fbm_pkg::FADE_15;

  logic [31:0] t2x, t2y, t3x, t3y;
  logic signed [40:0] ux, uy;
  logic [31:0] h00, h10, h01, h11;
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [37:0] lx0, lx1;
  logic signed [40:0] ly;
  logic signed [22:0] dny;

  always_comb begin
    t2x = 32'(tx) * 32'(tx);
    t2y = 32'(ty) * 32'(ty);
    t3x = 32'(t2x1_q) * 32'(tx1_q);
    t3y = 32'(t2y1_q) * 32'(ty1_q);
    ux  = 41'($signed({1'b0, t3x2_q})) * 41'(bx2_q);
    uy  = 41'($signed({1'b0, t3y2_q})) * 41'(by2_q);
    h00 = fbm_pkg::mul32(fbm_pkg::fold(g0_q ^ my0_2q), fbm_pkg::HASH_MUL_A);
    h10 = fbm_pkg::mul32(fbm_pkg::fold(g1_q ^ my0_2q), fbm_pkg::HASH_MUL_A);
    h01 = fbm_pkg::mul32(fbm_pkg::fold(g0_q ^ my1_2q), fbm_pkg::HASH_MUL_A);
    h11 = fbm_pkg::mul32(fbm_pkg::fold(g1_q ^ my1_2q), fbm_pkg::HASH_MUL_A);
    dx0 = $signed({2'b00, tx3_q});
    dy0 = $signed({2'b00, ty3_q});
    dx1 = 18'(19'(dx0) - fbm_pkg::ONE_Q16);
    dy1 = 18'(19'(dy0) - fbm_pkg::ONE_Q16);
    lx0 = 38'(u4_q) * 38'(20'(n10_q) - 20'(n00_q));
    lx1 = 38'(u4_q) * 38'(20'(n11_q) - 20'(n01_q));
    dny = 23'(nx1_q) - 23'(nx0_q);
    ly  = 41'(v5_q) * 41'(dny);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= 57'(coord_x_i) * 57'($signed({1'b0, freq_i}));
      py_q <= 57'(coord_y_i) * 57'($signed({1'b0, freq_i}));

      mx0_q  <= fbm_pkg::mul32(ix, fbm_pkg::HASH_MUL_A);
      mx1_q  <= fbm_pkg::mul32(ix + 32'd1, fbm_pkg::HASH_MUL_A);
      my0_q  <= fbm_pkg::mul32(iy, fbm_pkg::HASH_MUL_B);
      my1_q  <= fbm_pkg::mul32(iy + 32'd1, fbm_pkg::HASH_MUL_B);
      tx1_q  <= tx;
      ty1_q  <= ty;
      t2x1_q <= t2x[31:16];
      t2y1_q <= t2y[31:16];
      tax1_q <= 40'(tsx) * 40'(ax);
      tay1_q <= 40'(tsy) * 40'(ay);

      g0_q   <= fbm_pkg::mul32(fbm_pkg::fold(seed_i ^ mx0_q), fbm_pkg::HASH_MUL_A);
      g1_q   <= fbm_pkg::mul32(fbm_pkg::fold(seed_i ^ mx1_q), fbm_pkg::HASH_MUL_A);
      my0_2q <= my0_q;
      my1_2q <= my1_q;
      tx2_q  <= tx1_q;
      ty2_q  <= ty1_q;
      t3x2_q <= t3x[31:16];
      t3y2_q <= t3y[31:16];
      bx2_q  <= 24'(tax1_q >>> 16) + fbm_pkg::FADE_10;
      by2_q  <= 24'(tay1_q >>> 16) + fbm_pkg::FADE_10;

      // low gradient bits of the final fold
      c00_q <= h00[2:0] ^ h00[18:16];
      c10_q <= h10[2:0] ^ h10[18:16];
      c01_q <= h01[2:0] ^ h01[18:16];
      c11_q <= h11[2:0] ^ h11[18:16];
      tx3_q <= tx2_q;
      ty3_q <= ty2_q;
      u3_q  <= 18'(ux >>> 16);
      v3_q  <= 18'(uy >>> 16);

      n00_q <= fbm_pkg::grad_dot(c00_q, dx0, dy0);
      n10_q <= fbm_pkg::grad_dot(c10_q, dx1, dy0);
      n01_q <= fbm_pkg::grad_dot(c01_q, dx0, dy1);
      n11_q <= fbm_pkg::grad_dot(c11_q, dx1, dy1);
      u4_q  <= u3_q;
      v4_q  <= v3_q;

      nx0_q <= 22'(n00_q) + 22'(lx0 >>> 16);
      nx1_q <= 22'(n01_q) + 22'(lx1 >>> 16);
      v5_q  <= v4_q;

      n6_q <= 26'(nx0_q) + 26'(ly >>> 16);

      term_q <= active_i
          ? fbm_pkg::TERM_W'(n6_q) * fbm_pkg::TERM_W'($signed({1'b0, amp_i}))
          : '0;
    end
  end

  assign term_o = term_q;

endmodule

[sim/fbm_perlin_noise_2d_tb.sv]
// self-checking testbench for fbm_perlin_noise_2d: coordinate items in, noise items out
// predicts each noise item with its own fixed-point fbm model unless a known value is given; depends on fbm_pkg
module fbm_perlin_noise_2d_tb;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [fbm_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [fbm_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic signed [31:0]             coord_x_i;
  logic signed [31:0]             coord_y_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic signed [15:0]             noise_value_o;

  fbm_perlin_noise_2d DUT (.*);

  // predictor copy of the registers
  logic [31:0] seed_q;
  logic [3:0]  oct_q;
  logic [23:0] freq_q;
  logic [15:0] lac_q;
  logic [15:0] pers_q;
  logic [15:0] recip_q;

  logic signed [15:0] noise_queue[$];
  int unsigned errors;
  int unsigned cycles;
  bit          quiet;     // no idling in the last part of the run

  localparam int unsigned CYCLE_LIMIT = 1000000;
  // index past the register list
  localparam logic [fbm_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic longint fshift(input longint v, input int s);
    return v >>> s;   // arithmetic shift is a floor shift
  endfunction

  function automatic logic [15:0] eff_pers();
    return (pers_q > fbm_pkg::AMP_ONE) ? fbm_pkg::AMP_ONE : pers_q;
  endfunction

  function automatic int unsigned eff_oct();
    return (oct_q > fbm_pkg::MAX_OCTAVES_DEF) ? fbm_pkg::MAX_OCTAVES_DEF : oct_q;
  endfunction

  function automatic void update_recip();
    longint amp, total;
    total = 0;
    amp = 32768;
    for (int i = 0; i < eff_oct(); i++) begin
      total += amp;
      amp = (amp * eff_pers()) >> 15;
    end
    recip_q = (total != 0) ? 16'((64'd1 << 30) / total) : 16'd0;
  endfunction

  function automatic logic [31:0] corner_hash(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] s);
    logic [31:0] h;
    h = s ^ (x * fbm_pkg::HASH_MUL_A);
    h = ((h >> 16) ^ h) * fbm_pkg::HASH_MUL_A;
    h = h ^ (y * fbm_pkg::HASH_MUL_B);
    h = ((h >> 16) ^ h) * fbm_pkg::HASH_MUL_A;
    return (h >> 16) ^ h;
  endfunction

  function automatic longint gradient(input logic [31:0] h, input longint dx, input longint dy);
    case (h[2:0])
      3'd0: return dx + dy;
      3'd1: return dy - dx;
      3'd2: return dx - dy;
      3'd3: return -dx - dy;
      3'd4: return dx;
      3'd5: return -dx;
      3'd6: return dy;
      default: return -dy;
    endcase
  endfunction

  function automatic longint fade_q16(input longint t);
    longint a, b, t2, t3;
    a = 6 * t - 15 * 65536;
    b = fshift(t * a, 16) + 10 * 65536;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    return fshift(t3 * b, 16);
  endfunction

  function automatic longint lerp_q16(input longint lo, input longint hi, input longint u);
    return lo + fshift(u * (hi - lo), 16);
  endfunction

  function automatic longint octave_noise(input longint x, input longint y,
                                          input longint f, input logic [31:0] s);
    longint px, py, fx, fy, u, v, n00, n10, n01, n11;
    logic [31:0] ix, iy;
    px = fshift(x * f, 16);
    py = fshift(y * f, 16);
    ix = 32'(px >>> 16);
    iy = 32'(py >>> 16);
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    u = fade_q16(fx);
    v = fade_q16(fy);
    n00 = gradient(corner_hash(ix, iy, s), fx, fy);
    n10 = gradient(corner_hash(ix + 1, iy, s), fx - 65536, fy);
    n01 = gradient(corner_hash(ix, iy + 1, s), fx, fy - 65536);
    n11 = gradient(corner_hash(ix + 1, iy + 1, s), fx - 65536, fy - 65536);
    return lerp_q16(lerp_q16(n00, n10, u), lerp_q16(n01, n11, u), v);
  endfunction

  function automatic logic signed [15:0] fbm_noise(input logic signed [31:0] cx,
                                                   input logic signed [31:0] cy);
    longint f, amp, total, r;
    f = freq_q;
    amp = 32768;
    total = 0;
    for (int i = 0; i < eff_oct(); i++) begin
      total += octave_noise(cx, cy, f, seed_q + i) * amp;
      amp = (amp * eff_pers()) >> 15;
      f = (f * lac_q) >> 12;
      if (f > 64'hFFFFFF) f = 64'hFFFFFF;
    end
    r = fshift(total * longint'(recip_q), 31);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // register write at one rising edge, then write enable dropped and the predictor copy updated
  task automatic write_reg(input logic [fbm_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      fbm_pkg::CFG_SEED:    seed_q = val;
      fbm_pkg::CFG_OCTAVES: oct_q  = val[3:0];
      fbm_pkg::CFG_BASE_FQ: freq_q = val[23:0];
      fbm_pkg::CFG_LACUN:   lac_q  = val[15:0];
      fbm_pkg::CFG_PERSIST: pers_q = val[15:0];
      default: return;   // out-of-range index: no effect
    endcase
    update_recip();
  endtask

  // present one item; a known expectation overrides the predictor
  task automatic send_coord(input logic [31:0] x, input logic [31:0] y,
                            input bit has_exp, input logic signed [15:0] exp_val);
    int gap;
    logic signed [15:0] want;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    do @(posedge clk_i); while (!in_ready_o);
    want = has_exp ? exp_val : fbm_noise(x, y);
    noise_queue = {noise_queue, want};
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (noise_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // receiver: random stall bursts
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 18);
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // checker: sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (noise_queue.size() == 0) report_mismatch("noise item with nothing expected");
      else begin
        logic signed [15:0] want;
        want = noise_queue.pop_front();
        if (noise_value_o !== want)
          report_mismatch($sformatf("noise_value got %0d want %0d", noise_value_o, want));
      end
    end
  end

  typedef struct {
    logic [31:0]        x;
    logic [31:0]        y;
    bit                 known;
    logic signed [15:0] val;
  } coord_row_t;

  coord_row_t directed_rows[] = '{
    '{32'h0,        32'h0,        1, 16'sd0},   // lattice points give zero
    '{32'h0001_0000, 32'h0003_0000, 0, 16'sd0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'sd0},
    '{32'h8000_0000, 32'h8000_0000, 0, 16'sd0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 0, 16'sd0},
    '{32'h0000_8000, 32'h0000_8000, 0, 16'sd0},
    '{32'hFFFF_FFFF, 32'h0000_0001, 0, 16'sd0},
    '{32'h0000_FFFF, 32'hFFFF_0000, 0, 16'sd0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 0, 16'sd0},
    '{32'hFFFF_8000, 32'h0000_4000, 0, 16'sd0}
  };

  task automatic run_directed();
    foreach (directed_rows[i])
      send_coord(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
                 directed_rows[i].val);
  endtask

  task automatic run_random(input int n);
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin x = $urandom; y = $urandom; end
        1: begin x = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                 y = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000; end
        2: begin x = {$urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF, 16'($urandom)};
                 y = $urandom; end
        default: begin x = $urandom & 32'h0003_FFFF; y = $urandom & 32'h0003_FFFF; end
      endcase
      send_coord(x, y, 0, 16'sd0);
    end
  endtask

  initial begin
    errors = 0; cycles = 0; quiet = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = fbm_pkg::CFG_SEED; cfg_data_i = '0;
    in_valid_i = 1'b0; coord_x_i = '0; coord_y_i = '0;
    seed_q = fbm_pkg::RST_SEED; oct_q = fbm_pkg::RST_OCTAVES; freq_q = fbm_pkg::RST_BASE_FQ;
    lac_q = fbm_pkg::RST_LACUN; pers_q = fbm_pkg::RST_PERSIST;
    update_recip();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings
    run_directed();
    run_random(200);
    wait_drained();   // sender holds off until every item has come back

    // zero octaves: always zero
    write_reg(fbm_pkg::CFG_OCTAVES, 32'd0);
    send_coord(32'h1234_5678, 32'h8765_4321, 1, 16'sd0);
    send_coord(32'h8000_0000, 32'h7FFF_FFFF, 1, 16'sd0);
    wait_drained();

    // extremes: max octaves, saturating frequency, persistence above one
    write_reg(fbm_pkg::CFG_SEED, 32'hFFFF_FFFF);
    write_reg(fbm_pkg::CFG_OCTAVES, 32'd15);
    write_reg(fbm_pkg::CFG_BASE_FQ, 32'hFFFF_FFFF);
    write_reg(fbm_pkg::CFG_LACUN, 32'h0000_FFFF);
    write_reg(fbm_pkg::CFG_PERSIST, 32'h0000_FFFF);
    write_reg(CFG_IDX_NONE, 32'hDEAD_BEEF);   // ignored index
    run_directed();
    run_random(200);
    wait_drained();

    // minimum frequency and lacunarity
    write_reg(fbm_pkg::CFG_SEED, 32'h0);
    write_reg(fbm_pkg::CFG_OCTAVES, 32'd1);
    write_reg(fbm_pkg::CFG_BASE_FQ, 32'd0);
    write_reg(fbm_pkg::CFG_LACUN, 32'd0);
    write_reg(fbm_pkg::CFG_PERSIST, 32'd0);
    send_coord(32'h7FFF_FFFF, 32'h8000_0000, 1, 16'sd0);
    run_random(50);
    wait_drained();

    // random settings
    for (int p = 0; p < 6; p++) begin
      write_reg(fbm_pkg::CFG_SEED, $urandom);
      write_reg(fbm_pkg::CFG_OCTAVES, $urandom_range(0, 15));
      write_reg(fbm_pkg::CFG_BASE_FQ, $urandom_range(0, 32'h0004_0000));
      write_reg(fbm_pkg::CFG_LACUN, $urandom_range(0, 32'h0000_FFFF));
      write_reg(fbm_pkg::CFG_PERSIST, $urandom_range(0, 32'h0000_FFFF));
      if (p == 5) quiet = 1;
      run_random(130);
      wait_drained();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
